// File: hdl/modal_resonator_bank_core_defines.svh
// Assertion macros for the modal resonator bank core.
`ifndef MODAL_RESONATOR_BANK_CORE_DEFINES_SVH
`define MODAL_RESONATOR_BANK_CORE_DEFINES_SVH

// same-cycle implication
`define MRB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mrb assertion failed");

// next-cycle implication
`define MRB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mrb assertion failed");

`endif

// File: hdl/mrb_pkg.sv
// Types, constants and arithmetic helpers of the modal resonator bank.
package mrb_pkg;

    localparam int ST_W      = 40;
    localparam int COEF_W    = 24;
    localparam int A2_W      = 23;
    localparam int SMP_W     = 16;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 3;
    localparam int MAX_SUM_W = 48;
    localparam int PROD_W    = 82;

    localparam logic [16:0] UNITY = 17'd65536;
    localparam logic signed [47:0] ST_MAX = 48'sd549755813887;
    localparam logic signed [47:0] ST_MIN = -48'sd549755813888;
    localparam logic signed [20:0] S16_MAX = 21'sd32767;
    localparam logic signed [20:0] S16_MIN = -21'sd32768;
    localparam logic [PROD_W-1:0] WET_LIMIT = PROD_W'(1) << 62;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACTIVE_MODES = 3'd0,
        REG_STEREO       = 3'd1,
        REG_WET_MIX      = 3'd2,
        REG_WET_GAIN     = 3'd3,
        REG_FLUSH_LEVEL  = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CMD_PROCESS = 2'd0,
        CMD_LOAD    = 2'd1,
        CMD_CLEAR   = 2'd2
    } cmd_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD,
        ST_CHK,
        ST_Y0,
        ST_A1L,
        ST_A1H,
        ST_A2L,
        ST_A2H,
        ST_WB,
        ST_MG,
        ST_SL,
        ST_SH,
        ST_DRY,
        ST_FIN,
        ST_OUT
    } state_t;

    function automatic logic signed [ST_W-1:0] sat40(input logic signed [47:0] v);
        logic signed [47:0] r;
        begin
            if (v > ST_MAX)
                r = ST_MAX;
            else if (v < ST_MIN)
                r = ST_MIN;
            else
                r = v;
            return r[ST_W-1:0];
        end
    endfunction

    // shift right by 22, round half away from zero
    function automatic logic signed [44:0] rshift22(input logic signed [65:0] f);
        logic [65:0] mag;
        logic [65:0] sh;
        logic [44:0] r;
        begin
            mag = f[65] ? 66'(-f) : 66'(f);
            sh = (mag + (66'd1 << 21)) >> 22;
            r = {1'b0, sh[43:0]};
            return f[65] ? -$signed(r) : $signed(r);
        end
    endfunction

    function automatic logic tiny(input logic signed [ST_W-1:0] v, input logic [7:0] fl);
        logic signed [40:0] lim;
        logic signed [40:0] ve;
        begin
            lim = $signed({33'd0, fl});
            ve = 41'(v);
            return (ve < lim) && (ve > -lim);
        end
    endfunction

endpackage

// File: hdl/modal_resonator_bank_core.sv
// Modal resonator bank core: sequencer, shared multiplier, state and coefficient memories.
// Process: a running mode passes read, check, y0, a1/a2 halves and write-back, a skipped mode
// read and check only; then mix and output. Load and undefined commands go straight to output;
// clear zeroes the MODES*CHANNELS state words, then outputs. Throughput is one item at a time;
// the single shared 25x35 multiplier sets the pace. After reset a clearing pass zeroes state and
// coefficients; input is not accepted during it. Configuration resets to its documented defaults.
`include "modal_resonator_bank_core_defines.svh"

module modal_resonator_bank_core #(
    parameter int MODES    = 32,
    parameter int CHANNELS = 2
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [mrb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mrb_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        command,
    input  logic                              channel,
    input  logic signed [mrb_pkg::SMP_W-1:0]  sample,
    input  logic [4:0]                        mode_index,
    input  logic signed [mrb_pkg::COEF_W-1:0] coef_input,
    input  logic signed [mrb_pkg::COEF_W-1:0] coef_first_pole,
    input  logic [mrb_pkg::A2_W-1:0]          coef_second_pole,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [mrb_pkg::SMP_W-1:0]  out_sample,
    output logic                              all_silent
);

    localparam int WORDS   = MODES * CHANNELS;
    localparam int W_AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int MODE_AW = (MODES > 1) ? $clog2(MODES) : 1;
    localparam int LIVE_W  = $clog2(WORDS + 1);
    localparam int SUM_W   = mrb_pkg::ST_W + $clog2(MODES);
    localparam int COEF_MW = 2 * mrb_pkg::COEF_W + mrb_pkg::A2_W;

    // configuration
    logic [5:0]  active_modes_reg;
    logic        stereo_reg;
    logic [16:0] wet_mix_reg;
    logic [16:0] wet_gain_reg;
    logic [7:0]  flush_level_reg;

    // control
    mrb_pkg::state_t    state_reg, state_next;
    logic [MODE_AW-1:0] m_reg;
    logic [W_AW-1:0]    clr_reg;
    logic               clr_coef_reg;
    logic [LIVE_W-1:0]  live_reg;
    logic               out_valid_reg;

    // datapath
    logic signed [mrb_pkg::SMP_W-1:0] x_reg;
    logic                             ch_reg;
    logic signed [59:0]               p_reg;
    logic signed [59:0]               lo_reg;
    logic signed [mrb_pkg::ST_W-1:0]  y0_reg;
    logic signed [mrb_pkg::ST_W-1:0]  s1n_reg;
    logic signed [SUM_W-1:0]          sum_reg;
    logic [32:0]                      mg_reg;
    logic [mrb_pkg::PROD_W-1:0]       prod_reg;
    logic signed [mrb_pkg::SMP_W-1:0] y_reg;
    logic signed [mrb_pkg::SMP_W-1:0] out_sample_reg;
    logic                             all_silent_reg;

    // memories
    logic [2*mrb_pkg::ST_W-1:0] state_mem [WORDS];
    logic [COEF_MW-1:0]         coef_mem [MODES];
    logic [2*mrb_pkg::ST_W-1:0] rd_state;
    logic [COEF_MW-1:0]         rd_coef;

    logic                              accept;
    logic                              out_slot;
    logic                              clr_done;
    logic                              is_last;
    logic                              skip;
    logic [8:0]                        am9;
    logic [MODE_AW-1:0]                last_mode;
    logic [MODE_AW:0]                  w_wide;
    logic [W_AW-1:0]                   w_addr;
    logic                              stereo_eff;
    logic [16:0]                       mix_eff;
    logic [16:0]                       gain_eff;
    logic [16:0]                       dry;
    logic signed [mrb_pkg::ST_W-1:0]   rd_s1;
    logic signed [mrb_pkg::ST_W-1:0]   rd_s2;
    logic signed [mrb_pkg::COEF_W-1:0] rd_b0;
    logic signed [mrb_pkg::COEF_W-1:0] rd_a1;
    logic [mrb_pkg::A2_W-1:0]          rd_a2;
    logic                              was_live;
    logic signed [24:0]                op_a;
    logic signed [34:0]                op_b;
    logic signed [47:0]                y0_sum;
    logic signed [65:0]                full;
    logic signed [44:0]                t_round;
    logic signed [mrb_pkg::ST_W-1:0]   s2_raw;
    logic signed [mrb_pkg::ST_W-1:0]   s1_fin;
    logic signed [mrb_pkg::ST_W-1:0]   s2_fin;
    logic                              now_live;
    logic [SUM_W-1:0]                  smag;
    logic [47:0]                       smag48;
    logic signed [65:0]                acc;
    logic [65:0]                       acc_mag;
    logic [65:0]                       acc_sh;
    logic signed [20:0]                r_val;
    logic signed [mrb_pkg::SMP_W-1:0]  y_fin;

    assign in_ready   = (state_reg == mrb_pkg::ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign out_slot   = !out_valid_reg || out_ready;
    assign clr_done   = (clr_reg == W_AW'(WORDS - 1));
    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign all_silent = all_silent_reg;

    always_comb
    begin
        am9 = {3'd0, active_modes_reg};
        if (am9 == 9'd0)
            am9 = 9'd1;
        if (32'(am9) > MODES)
            am9 = 9'(MODES);
        last_mode = MODE_AW'(am9 - 9'd1);
    end

    assign is_last    = (m_reg == last_mode);
    assign stereo_eff = (CHANNELS > 1) && stereo_reg;
    assign w_wide     = stereo_eff ? {m_reg, ch_reg} : {1'b0, m_reg};
    assign w_addr     = w_wide[W_AW-1:0];

    assign mix_eff  = (wet_mix_reg > mrb_pkg::UNITY) ? mrb_pkg::UNITY : wet_mix_reg;
    assign gain_eff = (wet_gain_reg > mrb_pkg::UNITY) ? mrb_pkg::UNITY : wet_gain_reg;
    assign dry      = mrb_pkg::UNITY - mix_eff;

    assign rd_s1    = $signed(rd_state[2*mrb_pkg::ST_W-1:mrb_pkg::ST_W]);
    assign rd_s2    = $signed(rd_state[mrb_pkg::ST_W-1:0]);
    assign rd_b0    = $signed(rd_coef[COEF_MW-1 -: mrb_pkg::COEF_W]);
    assign rd_a1    = $signed(rd_coef[mrb_pkg::A2_W +: mrb_pkg::COEF_W]);
    assign rd_a2    = rd_coef[mrb_pkg::A2_W-1:0];
    assign was_live = (rd_state != '0);
    assign skip     = ((rd_b0 == '0) || (x_reg == '0)) && !was_live;

    assign y0_sum  = 48'($signed(p_reg[39:0])) + 48'(rd_s1);
    assign full    = (66'(p_reg) <<< 20) + 66'(lo_reg);
    assign t_round = mrb_pkg::rshift22(full);
    assign s2_raw  = mrb_pkg::sat40(-48'(t_round));

    always_comb
    begin
        s1_fin = s1n_reg;
        s2_fin = s2_raw;
        if (mrb_pkg::tiny(s1n_reg, flush_level_reg) && mrb_pkg::tiny(s2_raw, flush_level_reg))
        begin
            s1_fin = '0;
            s2_fin = '0;
        end
    end

    assign now_live = (s1_fin != '0) || (s2_fin != '0);
    assign smag     = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign smag48   = 48'(smag);

    // final mix: p_reg holds dry*x, prod_reg holds |sum|*mix*gain
    always_comb
    begin
        acc = (66'(p_reg) <<< 30);
        if (sum_reg[SUM_W-1])
            acc = acc - $signed(prod_reg[65:0]);
        else
            acc = acc + $signed(prod_reg[65:0]);
        acc_mag = acc[65] ? 66'(-acc) : 66'(acc);
        acc_sh  = (acc_mag + (66'd1 << 45)) >> 46;
        r_val   = acc[65] ? -$signed({1'b0, acc_sh[19:0]}) : $signed({1'b0, acc_sh[19:0]});
        if (prod_reg > mrb_pkg::WET_LIMIT)
            y_fin = sum_reg[SUM_W-1] ? mrb_pkg::SMP_W'(mrb_pkg::S16_MIN)
                                     : mrb_pkg::SMP_W'(mrb_pkg::S16_MAX);
        else if (r_val > mrb_pkg::S16_MAX)
            y_fin = mrb_pkg::SMP_W'(mrb_pkg::S16_MAX);
        else if (r_val < mrb_pkg::S16_MIN)
            y_fin = mrb_pkg::SMP_W'(mrb_pkg::S16_MIN);
        else
            y_fin = r_val[mrb_pkg::SMP_W-1:0];
    end

    // shared multiplier operand select
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        unique case (state_reg)
            mrb_pkg::ST_CHK:
            begin
                op_a = 25'(rd_b0);
                op_b = 35'(x_reg);
            end
            mrb_pkg::ST_A1L:
            begin
                op_a = 25'(rd_a1);
                op_b = $signed({15'd0, y0_reg[19:0]});
            end
            mrb_pkg::ST_A1H:
            begin
                op_a = 25'(rd_a1);
                op_b = 35'($signed(y0_reg[39:20]));
            end
            mrb_pkg::ST_A2L:
            begin
                op_a = $signed({2'd0, rd_a2});
                op_b = $signed({15'd0, y0_reg[19:0]});
            end
            mrb_pkg::ST_A2H:
            begin
                op_a = $signed({2'd0, rd_a2});
                op_b = 35'($signed(y0_reg[39:20]));
            end
            mrb_pkg::ST_MG:
            begin
                op_a = $signed({8'd0, mix_eff});
                op_b = $signed({18'd0, gain_eff});
            end
            mrb_pkg::ST_SL:
            begin
                op_a = $signed({1'b0, smag48[23:0]});
                op_b = $signed({1'b0, p_reg[33:0]});
            end
            mrb_pkg::ST_SH:
            begin
                op_a = $signed({1'b0, smag48[47:24]});
                op_b = $signed({2'd0, mg_reg});
            end
            mrb_pkg::ST_DRY:
            begin
                op_a = $signed({8'd0, dry});
                op_b = 35'(x_reg);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mrb_pkg::ST_CLEAR:
                if (clr_done)
                    state_next = clr_coef_reg ? mrb_pkg::ST_IDLE : mrb_pkg::ST_OUT;
            mrb_pkg::ST_IDLE:
                if (accept)
                begin
                    unique case (command)
                        mrb_pkg::CMD_PROCESS: state_next = mrb_pkg::ST_RD;
                        mrb_pkg::CMD_CLEAR:   state_next = mrb_pkg::ST_CLEAR;
                        default:              state_next = mrb_pkg::ST_OUT;
                    endcase
                end
            mrb_pkg::ST_RD:  state_next = mrb_pkg::ST_CHK;
            mrb_pkg::ST_CHK:
                if (skip)
                    state_next = is_last ? mrb_pkg::ST_MG : mrb_pkg::ST_RD;
                else
                    state_next = mrb_pkg::ST_Y0;
            mrb_pkg::ST_Y0:  state_next = mrb_pkg::ST_A1L;
            mrb_pkg::ST_A1L: state_next = mrb_pkg::ST_A1H;
            mrb_pkg::ST_A1H: state_next = mrb_pkg::ST_A2L;
            mrb_pkg::ST_A2L: state_next = mrb_pkg::ST_A2H;
            mrb_pkg::ST_A2H: state_next = mrb_pkg::ST_WB;
            mrb_pkg::ST_WB:  state_next = is_last ? mrb_pkg::ST_MG : mrb_pkg::ST_RD;
            mrb_pkg::ST_MG:  state_next = mrb_pkg::ST_SL;
            mrb_pkg::ST_SL:  state_next = mrb_pkg::ST_SH;
            mrb_pkg::ST_SH:  state_next = mrb_pkg::ST_DRY;
            mrb_pkg::ST_DRY: state_next = mrb_pkg::ST_FIN;
            mrb_pkg::ST_FIN: state_next = mrb_pkg::ST_OUT;
            mrb_pkg::ST_OUT:
                if (out_slot)
                    state_next = mrb_pkg::ST_IDLE;
            default: state_next = mrb_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= mrb_pkg::ST_CLEAR;
        else
            state_reg <= state_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_modes_reg <= 6'd1;
            stereo_reg       <= 1'b0;
            wet_mix_reg      <= mrb_pkg::UNITY;
            wet_gain_reg     <= 17'd4096;
            flush_level_reg  <= 8'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mrb_pkg::REG_ACTIVE_MODES: active_modes_reg <= cfg_data[5:0];
                mrb_pkg::REG_STEREO:       stereo_reg       <= cfg_data[0];
                mrb_pkg::REG_WET_MIX:      wet_mix_reg      <= cfg_data;
                mrb_pkg::REG_WET_GAIN:     wet_gain_reg     <= cfg_data;
                mrb_pkg::REG_FLUSH_LEVEL:  flush_level_reg  <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_reg         <= '0;
            clr_reg       <= '0;
            clr_coef_reg  <= 1'b1;
            live_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == mrb_pkg::ST_OUT) && out_slot)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                mrb_pkg::ST_CLEAR:
                begin
                    clr_reg <= clr_reg + W_AW'(1);
                    if (clr_done)
                        clr_coef_reg <= 1'b0;
                end
                mrb_pkg::ST_IDLE:
                    if (accept)
                    begin
                        m_reg   <= '0;
                        clr_reg <= '0;
                        if (command == mrb_pkg::CMD_CLEAR)
                            live_reg <= '0;
                    end
                mrb_pkg::ST_CHK:
                    if (skip && !is_last)
                        m_reg <= m_reg + MODE_AW'(1);
                mrb_pkg::ST_WB:
                begin
                    if (was_live && !now_live && (live_reg != '0))
                        live_reg <= live_reg - LIVE_W'(1);
                    else if (!was_live && now_live)
                        live_reg <= live_reg + LIVE_W'(1);
                    if (!is_last)
                        m_reg <= m_reg + MODE_AW'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        p_reg <= op_a * op_b;
        unique case (state_reg)
            mrb_pkg::ST_IDLE:
                if (accept)
                begin
                    x_reg   <= sample;
                    ch_reg  <= channel;
                    sum_reg <= '0;
                    y_reg   <= '0;
                end
            mrb_pkg::ST_Y0:  y0_reg <= mrb_pkg::sat40(y0_sum);
            mrb_pkg::ST_A1H: lo_reg <= p_reg;
            mrb_pkg::ST_A2L: s1n_reg <= mrb_pkg::sat40(48'(rd_s2) - 48'(t_round));
            mrb_pkg::ST_A2H: lo_reg <= p_reg;
            mrb_pkg::ST_WB:  sum_reg <= sum_reg + SUM_W'(y0_reg);
            mrb_pkg::ST_SL:  mg_reg <= p_reg[32:0];
            mrb_pkg::ST_SH:  lo_reg <= p_reg;
            mrb_pkg::ST_DRY:
                prod_reg <= (mrb_pkg::PROD_W'(p_reg[56:0]) << 24)
                          + mrb_pkg::PROD_W'(lo_reg[56:0]);
            mrb_pkg::ST_FIN: y_reg <= y_fin;
            mrb_pkg::ST_OUT:
                if (out_slot)
                begin
                    out_sample_reg <= y_reg;
                    all_silent_reg <= (live_reg == '0);
                end
            default:
            begin
            end
        endcase
    end

    // resonator state memory
    always_ff @(posedge clk)
    begin
        if (state_reg == mrb_pkg::ST_CLEAR)
            state_mem[clr_reg] <= '0;
        else if (state_reg == mrb_pkg::ST_WB)
            state_mem[w_addr] <= {s1_fin, s2_fin};
        rd_state <= state_mem[w_addr];
    end

    // coefficient memory
    always_ff @(posedge clk)
    begin
        if ((state_reg == mrb_pkg::ST_CLEAR) && clr_coef_reg && (32'(clr_reg) < MODES))
            coef_mem[clr_reg[MODE_AW-1:0]] <= '0;
        else if (accept && (command == mrb_pkg::CMD_LOAD) && (32'(mode_index) < MODES))
            coef_mem[MODE_AW'(mode_index)] <= {coef_input, coef_first_pole, coef_second_pole};
        rd_coef <= coef_mem[m_reg];
    end

    `MRB_ASSERT_NEXT(a_out_drop, clk, rst_n, out_valid_reg && out_ready && (state_reg != mrb_pkg::ST_OUT), !out_valid_reg)
    `MRB_ASSERT_NEXT(a_clear_live, clk, rst_n, (state_reg == mrb_pkg::ST_CLEAR) && clr_done, live_reg == '0)
    `MRB_ASSERT_NOW(a_mode_bound, clk, rst_n, (state_reg == mrb_pkg::ST_RD) || (state_reg == mrb_pkg::ST_CHK) || (state_reg == mrb_pkg::ST_WB), m_reg <= last_mode)

endmodule

// File: bench/tb_top.sv
// Self-checking testbench for the modal resonator bank core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_UNDEF = 2'd3;
    localparam int NMODES = 32;
    localparam int NWORDS = 64;
    localparam longint S40_MAX = 64'sd549755813887;
    localparam longint S40_MIN = -64'sd549755813888;

    typedef struct {
        logic [1:0]         cmd;
        logic               ch;
        logic signed [15:0] smp;
        logic [4:0]         mi;
        logic signed [23:0] b0;
        logic signed [23:0] a1;
        logic [22:0]        a2;
        bit                 known;
        logic signed [15:0] k_out;
        logic               k_sil;
    } beat_t;

    typedef struct {
        logic signed [15:0] out;
        logic               sil;
    } res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [mrb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [mrb_pkg::CFG_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] command = '0;
    logic channel = 1'b0;
    logic signed [15:0] sample = '0;
    logic [4:0] mode_index = '0;
    logic signed [23:0] coef_input = '0;
    logic signed [23:0] coef_first_pole = '0;
    logic [22:0] coef_second_pole = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [15:0] out_sample;
    logic all_silent;

    modal_resonator_bank_core dut (.*);

    always #5 clk = ~clk;

    // shadow of the bank
    longint s1_mem[NWORDS];
    longint s2_mem[NWORDS];
    int b0_mem[NMODES];
    int a1_mem[NMODES];
    longint a2_mem[NMODES];
    int live_cnt;
    int unsigned r_modes = 1, r_stereo = 0, r_mix = 65536, r_gain = 4096, r_flush = 1;

    res_t pending[$];
    beat_t known_q[$];
    int errors = 0;
    bit quiet = 0;
    bit hold_long = 0;

    function automatic longint round_away(longint p, int sh);
        bit neg;
        longint unsigned mag;
        begin
            neg = p < 0;
            mag = neg ? longint'(-p) : p;
            mag = (mag + (64'd1 << (sh - 1))) >> sh;
            return neg ? -longint'(mag) : longint'(mag);
        end
    endfunction

    function automatic longint clip40(longint v);
        return v > S40_MAX ? S40_MAX : (v < S40_MIN ? S40_MIN : v);
    endfunction

    function automatic bit is_tiny(longint v);
        return v > -longint'(r_flush) && v < longint'(r_flush);
    endfunction

    function automatic logic signed [15:0] run_modes(longint x, int ch);
        int nch, c, modes, w;
        longint sum, y0, s1, s2, mix, gain, dry, mg, smag, acc, r;
        bit was, now;
        begin
            nch = r_stereo ? 2 : 1;
            c = (nch == 2) ? ch : 0;
            modes = r_modes < 1 ? 1 : (r_modes > NMODES ? NMODES : r_modes);
            sum = 0;
            for (int m = 0; m < modes; m++) begin
                w = m * nch + c;
                s1 = s1_mem[w];
                s2 = s2_mem[w];
                was = (s1 != 0 || s2 != 0);
                if ((b0_mem[m] == 0 || x == 0) && !was)
                    continue;
                y0 = clip40(longint'(b0_mem[m]) * x + s1);
                s1 = clip40(s2 - round_away(longint'(a1_mem[m]) * y0, 22));
                s2 = clip40(-round_away(a2_mem[m] * y0, 22));
                if (is_tiny(s1) && is_tiny(s2)) begin
                    s1 = 0;
                    s2 = 0;
                end
                s1_mem[w] = s1;
                s2_mem[w] = s2;
                now = (s1 != 0 || s2 != 0);
                if (was && !now && live_cnt > 0)
                    live_cnt--;
                if (!was && now)
                    live_cnt++;
                sum += y0;
            end
            mix = r_mix > 65536 ? 65536 : r_mix;
            gain = r_gain > 65536 ? 65536 : r_gain;
            dry = 65536 - mix;
            mg = mix * gain;
            smag = sum < 0 ? -sum : sum;
            if (mg != 0 && smag > (longint'(1) << 62) / mg)
                return sum < 0 ? -16'sd32768 : 16'sd32767;
            acc = sum * mg + dry * x * (longint'(1) << 30);
            r = round_away(acc, 46);
            if (r > 32767)
                r = 32767;
            if (r < -32768)
                r = -32768;
            return r[15:0];
        end
    endfunction

    function automatic res_t bank_step(beat_t b);
        res_t rs;
        begin
            rs.out = '0;
            case (b.cmd)
                mrb_pkg::CMD_PROCESS: rs.out = run_modes(longint'(b.smp), b.ch);
                mrb_pkg::CMD_LOAD: begin
                    b0_mem[b.mi] = b.b0;
                    a1_mem[b.mi] = b.a1;
                    a2_mem[b.mi] = longint'(b.a2);
                end
                mrb_pkg::CMD_CLEAR: begin
                    foreach (s1_mem[i]) begin
                        s1_mem[i] = 0;
                        s2_mem[i] = 0;
                    end
                    live_cnt = 0;
                end
                default: ;
            endcase
            rs.sil = (live_cnt == 0);
            return rs;
        end
    endfunction

    // input beat accepted: predict and queue
    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready) begin
            beat_t b;
            res_t rs;
            b.cmd = command;
            b.ch = channel;
            b.smp = sample;
            b.mi = mode_index;
            b.b0 = coef_input;
            b.a1 = coef_first_pole;
            b.a2 = coef_second_pole;
            rs = bank_step(b);
            if (known_q.size() > 0) begin
                b = known_q.pop_front();
                if (b.known && (rs.out !== b.k_out || rs.sil !== b.k_sil))
                    $display("%0t note: table value %0d/%0d differs from prediction %0d/%0d",
                             $time, b.k_out, b.k_sil, rs.out, rs.sil);
                if (b.known) begin
                    rs.out = b.k_out;
                    rs.sil = b.k_sil;
                end
            end
            pending.push_back(rs);
        end
    end

    // output beat check
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            res_t e;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t unexpected beat: out_sample %0d all_silent %0b",
                         $time, out_sample, all_silent);
            end else begin
                e = pending.pop_front();
                if (out_sample !== e.out) begin
                    errors++;
                    $display("%0t out_sample: expected %0d actual %0d", $time, e.out, out_sample);
                end
                if (all_silent !== e.sil) begin
                    errors++;
                    $display("%0t all_silent: expected %0b actual %0b", $time, e.sil, all_silent);
                end
            end
        end
    end

    // receiver
    initial begin
        @(posedge rst_n);
        forever begin
            if (hold_long) begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_long = 0;
            end else if (!quiet && $urandom_range(0, 2) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    task automatic send(beat_t b);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        known_q.push_back(b);
        in_valid <= 1'b1;
        command <= b.cmd;
        channel <= b.ch;
        sample <= b.smp;
        mode_index <= b.mi;
        coef_input <= b.b0;
        coef_first_pole <= b.a1;
        coef_second_pole <= b.a2;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending.size() != 0 || known_q.size() != 0 && pending.size() != 0)
            @(posedge clk);
        while (out_valid)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(mrb_pkg::cfg_reg_t idx, int unsigned val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[mrb_pkg::CFG_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            mrb_pkg::REG_ACTIVE_MODES: r_modes = val & 6'h3F;
            mrb_pkg::REG_STEREO:       r_stereo = val & 1;
            mrb_pkg::REG_WET_MIX:      r_mix = val & 17'h1FFFF;
            mrb_pkg::REG_WET_GAIN:     r_gain = val & 17'h1FFFF;
            mrb_pkg::REG_FLUSH_LEVEL:  r_flush = val & 8'hFF;
            default: ;
        endcase
    endtask

    function automatic beat_t mk(logic [1:0] cmd, logic ch, int smp, int mi,
                                 int b0, int a1, int a2);
        beat_t b;
        begin
            b.cmd = cmd;
            b.ch = ch;
            b.smp = smp[15:0];
            b.mi = mi[4:0];
            b.b0 = b0[23:0];
            b.a1 = a1[23:0];
            b.a2 = a2[22:0];
            b.known = 0;
            b.k_out = '0;
            b.k_sil = 1'b1;
            return b;
        end
    endfunction

    function automatic beat_t mk_known(beat_t b, int o, bit s);
        b.known = 1;
        b.k_out = o[15:0];
        b.k_sil = s;
        return b;
    endfunction

    function automatic beat_t rand_load();
        int a2, a1, lim;
        begin
            if ($urandom_range(0, 7) == 0)
                return mk(mrb_pkg::CMD_LOAD, 0, 0, $urandom_range(0, 31), $urandom, $urandom,
                          $urandom_range(0, 4194304));
            a2 = $urandom_range(3774873, 4194304);
            lim = 2 * $sqrt(real'(a2) * 4194304.0) - 1;
            a1 = $urandom_range(0, 2 * lim) - lim;
            return mk(mrb_pkg::CMD_LOAD, 0, 0, $urandom_range(0, 31),
                      $urandom_range(0, 262144) - 131072, a1, a2);
        end
    endfunction

    function automatic beat_t rand_proc(bit zero);
        int s;
        begin
            case ($urandom_range(0, 5))
                0: s = $urandom;
                1: s = $urandom_range(0, 1) ? 32767 : -32768;
                default: s = $urandom_range(0, 4000) - 2000;
            endcase
            return mk(mrb_pkg::CMD_PROCESS, 1'($urandom), zero ? 0 : s, $urandom, $urandom,
                      $urandom, $urandom);
        end
    endfunction

    beat_t rows[$];
    int unsigned modes_set[8] = '{63, 0, 32, 1, 5, 33, 12, 32};
    int unsigned mix_set[8] = '{131071, 0, 65536, 32768, 65536, 12000, 65535, 50000};
    int unsigned gain_set[8] = '{0, 131071, 65536, 4096, 4096, 256, 8192, 1};
    int unsigned flush_set[8] = '{0, 255, 1, 16, 2, 0, 64, 1};

    initial begin
        foreach (s1_mem[i]) begin
            s1_mem[i] = 0;
            s2_mem[i] = 0;
        end
        foreach (b0_mem[i]) begin
            b0_mem[i] = 0;
            a1_mem[i] = 0;
            a2_mem[i] = 0;
        end
        live_cnt = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows
        rows.push_back(mk_known(mk(mrb_pkg::CMD_PROCESS, 0, 1234, 0, 0, 0, 0), 0, 1));
        rows.push_back(mk_known(mk(CMD_UNDEF, 1, -1, 31, -1, -1, 8388607), 0, 1));
        rows.push_back(mk_known(mk(mrb_pkg::CMD_LOAD, 0, 0, 0, 262144, -8000000, 4000000),
                                0, 1));
        rows.push_back(mk(mrb_pkg::CMD_PROCESS, 0, 32767, 0, 0, 0, 0));
        rows.push_back(mk(mrb_pkg::CMD_PROCESS, 1, -32768, 0, 0, 0, 0));
        rows.push_back(mk(mrb_pkg::CMD_PROCESS, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(CMD_UNDEF, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_known(mk(mrb_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0), 0, 1));
        rows.push_back(mk_known(mk(mrb_pkg::CMD_LOAD, 0, 0, 31, 8388607, 8388607, 4194304),
                                0, 1));
        rows.push_back(mk_known(mk(mrb_pkg::CMD_LOAD, 0, 0, 1, -8388608, -8388608, 0), 0, 1));
        rows.push_back(mk(mrb_pkg::CMD_PROCESS, 0, 1, 0, 0, 0, 0));
        rows.push_back(mk(mrb_pkg::CMD_PROCESS, 1, -1, 0, 0, 0, 0));
        rows.push_back(mk(mrb_pkg::CMD_PROCESS, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(mrb_pkg::CMD_PROCESS, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_known(mk(mrb_pkg::CMD_CLEAR, 1, 0, 0, 0, 0, 0), 0, 1));
        foreach (rows[i])
            send(rows[i]);
        drain();

        // random phases under varied register settings
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(mrb_pkg::REG_ACTIVE_MODES, modes_set[ph]);
            write_reg(mrb_pkg::REG_STEREO, ph % 2);
            write_reg(mrb_pkg::REG_WET_MIX, mix_set[ph]);
            write_reg(mrb_pkg::REG_WET_GAIN, gain_set[ph]);
            write_reg(mrb_pkg::REG_FLUSH_LEVEL, flush_set[ph]);
            if (ph == 7)
                quiet = 1;
            for (int n = 0; n < 80; n++) begin
                if (ph == 2 && n == 20)
                    hold_long = 1;
                if (ph == 3 && n == 40)
                    drain();
                if (n < 12 && ph != 5)
                    send(rand_load());
                else if ($urandom_range(0, 29) == 0)
                    send(mk($urandom_range(0, 1) ? mrb_pkg::CMD_CLEAR : CMD_UNDEF,
                            1'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom));
                else if ($urandom_range(0, 19) == 0)
                    send(rand_load());
                else
                    send(rand_proc((n / 10) % 3 == 2));
            end
            drain();
        end

        drain();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("[modal_resonator_bank_core] OK");
        else
            $display("[modal_resonator_bank_core] ERROR");
        $finish;
    end

    initial begin
        #20ms;
        $display("[modal_resonator_bank_core] ERROR");
        $finish;
    end
endmodule
